// ----- sv/sts_pkg.sv -----
// ============================================================================
// Sorted table search package
// Sizes, codes and the controller state type shared by the search block.
// ============================================================================
`default_nettype none

package sts_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IDX_W       = ADDR_W + 1;

    localparam int DATA_W      = 32;
    localparam int INDEX_W     = 10;
    localparam int COUNT_W     = 11;
    localparam int POS_W       = 10;

    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 16;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FIRST = 4'b0010,
        S_LAST  = 4'b0100,
        S_PROBE = 4'b1000
    } state_t;

endpackage

`default_nettype wire

// ----- sv/sorted_table_binary_search.sv -----
// ============================================================================
// Sorted table binary search
// Holds a software-written ascending table and answers key searches.
// ============================================================================
// A write transfer (tuser 0) stores one entry. A search
// transfer (tuser 1) reads the first and last valid entries for the range
// check and then probes one entry per cycle. The result is registered and
// is given when a probe hits the key, when the probe range runs empty or
// when the range check fails. The next transfer can be taken at the edge
// of the result transfer. The single read port of the table memory is why
// the entries are read one after another. A search on an empty table
// answers in the cycle after the transfer. The block takes one transfer at
// a time.
`default_nettype none

module sorted_table_binary_search (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [sts_pkg::COUNT_W-1:0]    cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: entry_index[9:0], item_value[41:10], zero pad.
    input  wire logic [sts_pkg::S_TDATA_W-1:0]  s_tdata,
    // Fields from bit 0: mode.
    input  wire logic [0:0]                     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // Fields from bit 0: position[9:0], zero pad.
    output logic [sts_pkg::M_TDATA_W-1:0]       m_tdata,
    // Fields from bit 0: found.
    output logic [0:0]                          m_tuser
);

    localparam int AW = sts_pkg::ADDR_W;
    localparam int IW = sts_pkg::IDX_W;
    localparam int DW = sts_pkg::DATA_W;

    sts_pkg::state_t state_reg, state_next;

    logic [sts_pkg::COUNT_W-1:0] count_reg;
    logic signed [DW-1:0]        key_reg, key_next;
    logic [IW-1:0]               n_reg, n_next;
    logic [IW-1:0]               lo_reg, lo_next;
    logic [IW-1:0]               hi_reg, hi_next;
    logic [IW-1:0]               mid_reg, mid_next;
    logic                        ge_first_reg, ge_first_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_found_reg, out_found_next;
    logic [sts_pkg::POS_W-1:0]   out_pos_reg, out_pos_next;

    logic                        s_accept;
    logic [sts_pkg::INDEX_W-1:0] s_index;
    logic signed [DW-1:0]        s_value;

    logic                        ram_wr_en;
    logic [AW-1:0]               ram_rd_addr;
    logic [DW-1:0]               ram_rd_data;
    logic signed [DW-1:0]        entry;

    logic [IW-1:0]               last_idx;
    logic [IW-1:0]               probe_lo;
    logic [IW-1:0]               probe_hi;
    logic [IW:0]                 mid_sum;
    logic                        probe_empty;

    assign s_index  = s_tdata[sts_pkg::INDEX_W-1:0];
    assign s_value  = s_tdata[sts_pkg::INDEX_W +: DW];
    assign s_tready = (state_reg == sts_pkg::S_IDLE) && (!out_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign entry    = ram_rd_data;
    assign last_idx = n_reg - IW'(1);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = sts_pkg::M_TDATA_W'(out_pos_reg);
    assign m_tuser  = out_found_reg;

    sts_ram #(
        .DEPTH  (sts_pkg::TABLE_DEPTH),
        .ADDR_W (AW),
        .DATA_W (DW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (AW'(s_index)),
        .wr_data (s_value),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        probe_lo    = lo_reg;
        probe_hi    = hi_reg;
        probe_empty = 1'b0;
        if (entry > key_reg) begin
            if (mid_reg == '0) begin
                probe_empty = 1'b1;
            end else begin
                probe_hi = mid_reg - IW'(1);
            end
        end else begin
            probe_lo = mid_reg + IW'(1);
        end
        if (probe_lo > probe_hi) begin
            probe_empty = 1'b1;
        end
        mid_sum = {1'b0, probe_lo} + {1'b0, probe_hi};
    end

    always_comb begin
        state_next     = state_reg;
        key_next       = key_reg;
        n_next         = n_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        ge_first_next  = ge_first_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_found_next = out_found_reg;
        out_pos_next   = out_pos_reg;
        ram_wr_en      = 1'b0;
        ram_rd_addr    = '0;

        case (state_reg)
            sts_pkg::S_IDLE: begin
                if (s_accept) begin
                    if (s_tuser[0] == sts_pkg::MODE_WRITE) begin
                        ram_wr_en = (32'(s_index) < 32'(sts_pkg::TABLE_DEPTH));
                    end else begin
                        key_next = s_value;
                        if (32'(count_reg) > 32'(sts_pkg::TABLE_DEPTH)) begin
                            n_next = IW'(sts_pkg::TABLE_DEPTH);
                        end else begin
                            n_next = IW'(count_reg);
                        end
                        if (count_reg == '0) begin
                            out_valid_next = 1'b1;
                            out_found_next = 1'b0;
                            out_pos_next   = '0;
                        end else begin
                            state_next = sts_pkg::S_FIRST;
                        end
                    end
                end
            end
            sts_pkg::S_FIRST: begin
                ge_first_next = (key_reg >= entry);
                ram_rd_addr   = last_idx[AW-1:0];
                state_next    = sts_pkg::S_LAST;
            end
            sts_pkg::S_LAST: begin
                if (ge_first_reg && (key_reg <= entry)) begin
                    lo_next     = '0;
                    hi_next     = last_idx;
                    mid_next    = last_idx >> 1;
                    ram_rd_addr = mid_next[AW-1:0];
                    state_next  = sts_pkg::S_PROBE;
                end else begin
                    out_valid_next = 1'b1;
                    out_found_next = 1'b0;
                    out_pos_next   = '0;
                    state_next     = sts_pkg::S_IDLE;
                end
            end
            sts_pkg::S_PROBE: begin
                if (entry == key_reg) begin
                    out_valid_next = 1'b1;
                    out_found_next = 1'b1;
                    out_pos_next   = sts_pkg::POS_W'(mid_reg);
                    state_next     = sts_pkg::S_IDLE;
                end else if (probe_empty) begin
                    out_valid_next = 1'b1;
                    out_found_next = 1'b0;
                    out_pos_next   = '0;
                    state_next     = sts_pkg::S_IDLE;
                end else begin
                    lo_next     = probe_lo;
                    hi_next     = probe_hi;
                    mid_next    = mid_sum[IW:1];
                    ram_rd_addr = mid_next[AW-1:0];
                end
            end
            default: begin
                state_next = sts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sts_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                count_reg <= cfg_wdata;
            end
        end
        key_reg       <= key_next;
        n_reg         <= n_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        ge_first_reg  <= ge_first_next;
        out_found_reg <= out_found_next;
        out_pos_reg   <= out_pos_next;
    end

`ifndef SYNTHESIS
    a_probe_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sts_pkg::S_PROBE) |-> (lo_reg <= hi_reg) && (hi_reg < n_reg))
        else $error("probe range is empty or beyond the valid entries");

    a_probe_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sts_pkg::S_PROBE) |-> (mid_reg >= lo_reg) && (mid_reg <= hi_reg))
        else $error("probe position lies outside the search range");

    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_tuser[0] == sts_pkg::MODE_SEARCH))
        |=> (state_reg != sts_pkg::S_IDLE) || out_valid_reg)
        else $error("search transfer neither started nor answered");

    a_miss_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("not-found result carries a nonzero position");
`endif

endmodule

`default_nettype wire

// ----- sv/sts_ram.sv -----
// ============================================================================
// Table memory
// Single write port and single read port with registered read data.
// ============================================================================
`default_nettype none

module sts_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire
